### hw/rtl/tcptw_pkg.sv
package tcptw_pkg;

  localparam int WORD_W    = 32;
  localparam int MSS_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = WORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [MSS_W-1:0]  RST_MSS      = 16'd1460;
  localparam logic [WORD_W-1:0] RST_INIT_THR = 32'd65535;
  localparam logic [WORD_W-1:0] RST_WINDOW   = WORD_W'(RST_MSS);
  localparam logic [WORD_W-1:0] RST_THRESHOLD =
    (RST_INIT_THR > 2 * WORD_W'(RST_MSS)) ? RST_INIT_THR : 2 * WORD_W'(RST_MSS);
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  typedef enum logic [1:0] {
    FUNC_QUERY   = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_LOSS    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MSS      = 1'b0,
    REG_INIT_THR = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE,
    ST_REPORT
  } state_t;

endpackage

### hw/rtl/tcp_tahoe_window_control.sv
// An ack in congestion avoidance, with nonzero acked bytes and a nonzero window, runs the
// 32 steps of the restoring divider, one quotient bit per cycle, then update, then load.
// Every other event goes through the state update, then the result load.
// One event is handled at a time; the next is taken the cycle after the result is loaded,
// and a result held by out_stall keeps the next result waiting in the report step.
// Synchronous active-high reset: mss 1460, initial threshold 65535, window 1460, no result.
module tcp_tahoe_window_control (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tcptw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcptw_pkg::WORD_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tcptw_pkg::func_t                    func,
  input  logic [tcptw_pkg::WORD_W-1:0]        acked_bytes,
  input  logic [tcptw_pkg::WORD_W-1:0]        outstanding_bytes,
  input  logic [tcptw_pkg::WORD_W-1:0]        send_bytes,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                send_allowed,
  output logic [tcptw_pkg::WORD_W-1:0]        window_bytes,
  output logic [tcptw_pkg::WORD_W-1:0]        threshold_bytes,
  output logic                                slow_start
);
  import tcptw_pkg::*;

  state_t             state;
  state_t             state_next;

  logic [MSS_W-1:0]   mss;
  logic [WORD_W-1:0]  init_thr;
  logic [WORD_W-1:0]  window;
  logic [WORD_W-1:0]  threshold;
  logic [WORD_W-1:0]  window_next;
  logic [WORD_W-1:0]  threshold_next;

  func_t              func_q;
  logic [WORD_W-1:0]  acked_q;
  logic [WORD_W-1:0]  in_flight_q;
  logic [WORD_W-1:0]  seg_q;
  logic               avoid_q;

  logic [WORD_W-1:0]  quo;
  logic [WORD_W-1:0]  rem;
  logic [WORD_W-1:0]  divisor;
  logic [CNT_W-1:0]   div_count;
  logic [WORD_W:0]    rem_shift;
  logic [WORD_W+1:0]  trial;
  logic [WORD_W-1:0]  rem_next;
  logic [WORD_W-1:0]  quo_next;

  logic               in_acc;
  logic               go_div;
  logic               out_free;
  logic               load_out;

  logic [WORD_W-1:0]  twice_mss;
  logic [WORD_W-1:0]  mss_word;
  logic [WORD_W-1:0]  half_window;
  logic [WORD_W-1:0]  grow;
  logic [WORD_W:0]    grow_sum;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign mss_word  = WORD_W'(mss);
  assign twice_mss = {mss_word[WORD_W-2:0], 1'b0};
  assign go_div    = in_acc && (func == FUNC_ACK) && (acked_bytes != '0)
                     && (window >= threshold) && (window != '0);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = go_div ? ST_DIV : ST_UPDATE;
        end
      end
      ST_DIV: begin
        if (div_count == '0) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mss      <= RST_MSS;
      init_thr <= RST_INIT_THR;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MSS:      mss      <= cfg_data[MSS_W-1:0];
        REG_INIT_THR: init_thr <= cfg_data;
        default:      ;
      endcase
    end
  end

  // One restoring division step: one quotient bit per cycle.
  always_comb begin
    rem_shift = {rem, quo[WORD_W-1]};
    trial     = {1'b0, rem_shift} - {2'b00, divisor};
    if (trial[WORD_W+1]) begin
      rem_next = rem_shift[WORD_W-1:0];
      quo_next = {quo[WORD_W-2:0], 1'b0};
    end else begin
      rem_next = trial[WORD_W-1:0];
      quo_next = {quo[WORD_W-2:0], 1'b1};
    end
  end

  // Transaction capture and divider registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_q      <= func;
      acked_q     <= acked_bytes;
      in_flight_q <= outstanding_bytes;
      seg_q       <= send_bytes;
      avoid_q     <= window >= threshold;
      divisor     <= window;
      rem         <= '0;
      div_count   <= CNT_W'(DIV_STEPS - 1);
      // mss squared fits in one word, so it seeds the quotient register as the dividend.
      // A zero window skips the divider and leaves a zero quotient, giving a step of one.
      quo         <= go_div ? mss_word * mss_word : '0;
    end else if (state == ST_DIV) begin
      rem       <= rem_next;
      quo       <= quo_next;
      div_count <= div_count - 1'b1;
    end
  end

  // Window and threshold update.
  always_comb begin
    half_window    = {1'b0, window[WORD_W-1:1]};
    window_next    = window;
    threshold_next = threshold;
    if (avoid_q) begin
      grow = (quo == '0) ? WORD_W'(1) : quo;
    end else begin
      grow = (acked_q < mss_word) ? acked_q : mss_word;
    end
    grow_sum = {1'b0, window} + {1'b0, grow};
    unique case (func_q)
      FUNC_QUERY: ;
      FUNC_ACK: begin
        if (acked_q != '0) begin
          window_next = grow_sum[WORD_W] ? ALL_ONES : grow_sum[WORD_W-1:0];
        end
      end
      FUNC_LOSS: begin
        threshold_next = (half_window > twice_mss) ? half_window : twice_mss;
        window_next    = mss_word;
      end
      FUNC_RESTART: begin
        threshold_next = (init_thr > twice_mss) ? init_thr : twice_mss;
        window_next    = mss_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= RST_WINDOW;
      threshold <= RST_THRESHOLD;
    end else if (state == ST_UPDATE) begin
      window    <= window_next;
      threshold <= threshold_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      send_allowed    <= (in_flight_q <= window) && (seg_q <= window - in_flight_q);
      window_bytes    <= window;
      threshold_bytes <= threshold;
      slow_start      <= window < threshold;
    end
  end

`ifndef SYNTHESIS
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    go_div |=> (state == ST_DIV))
    else $error("congestion-avoidance ack did not start the divider");

  a_state_held_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |=> ($stable(window) && $stable(threshold)))
    else $error("window or threshold changed during division");

  a_ack_no_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && func_q == FUNC_ACK) |=> (window >= $past(window)))
    else $error("ack reduced the window");

  a_result_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_REPORT))
    else $error("result raised outside the report step");
`endif

endmodule
